[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define WGM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wgm assertion failed");

// Checked at every edge, reset included.
`define WGM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("wgm assertion failed");

`endif

[sv/wgm_pkg.sv]
`default_nettype none

package wgm_pkg;

  localparam int unsigned CharW        = 8;
  localparam int unsigned WordW        = 64;
  localparam int unsigned NumWords     = 4;
  localparam int unsigned PatternSlots = 32;
  localparam int unsigned LenW         = 6;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned QDepth       = 2;

  localparam logic [CharW-1:0] CharStar   = 8'h2A;
  localparam logic [CharW-1:0] CharQuery  = 8'h3F;
  localparam logic [CharW-1:0] LowerA     = 8'd97;
  localparam logic [CharW-1:0] LowerZ     = 8'd122;
  localparam logic [CharW-1:0] CaseOffset = 8'd32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WORD_A = 3'd0,
    REG_WORD_B = 3'd1,
    REG_WORD_C = 3'd2,
    REG_WORD_D = 3'd3,
    REG_LENGTH = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic                 last;
    logic [CharW-1:0]     ch;
  } item_t;

  typedef struct packed {
    logic                 we;
    logic [CfgIdxW-1:0]   idx;
    logic [WordW-1:0]     data;
  } cfg_wr_t;

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    if (c >= LowerA && c <= LowerZ) begin
      return c - CaseOffset;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/wgm_intf.sv]
`default_nettype none

interface wgm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink (input valid, input text_char, output ready);
endinterface

interface wgm_result_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

`default_nettype wire

[sv/wildcard_glob_matcher.sv]
`default_nettype none

// Case-insensitive glob matcher: text bytes stream in one transaction each;
// '*' matches any run, '?' one character, letters compare case-folded. A zero
// byte ends the text and yields one result transaction with matched, after
// which matching restarts at the pattern head. One byte per cycle unless a
// result stalls; a byte is queued when accepted and processed at the earliest
// in the next cycle, and a zero byte's result shows in the cycle after it is
// processed. The per-byte update with star closure is one PATTERN_MAX+1 bit
// carry chain. The pattern must be written through the cfg port while no text
// is in flight (unchecked); effective length is min(length, PATTERN_MAX, 32).
module wildcard_glob_matcher #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  wgm_text_if.sink                         text_in,
  wgm_result_if.source                     result_out,
  input  wire logic                        cfg_we_i,
  input  wire logic [wgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [wgm_pkg::WordW-1:0]   cfg_data_i
);
  import wgm_pkg::*;

  item_t   front_item, q_item;
  logic    push, full, q_valid, pop;
  cfg_wr_t cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  wgm_front u_front (
    .text_in (text_in),
    .full_i  (full),
    .item_o  (front_item),
    .push_o  (push)
  );

  wgm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  wgm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

[sv/wgm_front.sv]
`default_nettype none

module wgm_front (
  wgm_text_if.sink        text_in,
  input  wire logic       full_i,
  output wgm_pkg::item_t  item_o,
  output logic            push_o
);
  import wgm_pkg::*;

  assign text_in.ready = !full_i;
  assign push_o        = text_in.valid && !full_i;

  always_comb begin
    item_o.last = (text_in.text_char == '0);
    item_o.ch   = fold_case(text_in.text_char);
  end

endmodule

`default_nettype wire

[sv/wgm_queue.sv]
`default_nettype none

module wgm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire wgm_pkg::item_t  item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output wgm_pkg::item_t       item_o
);
  import wgm_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  item_t            mem_q [QDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    priority if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

`include "assert_macros.svh"

  `WGM_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CntW'(QDepth)))
  `WGM_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

[sv/wgm_back.sv]
`default_nettype none

module wgm_back #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire wgm_pkg::cfg_wr_t cfg_i,
  input  wire logic             q_valid_i,
  input  wire wgm_pkg::item_t   q_item_i,
  output logic                  pop_o,
  wgm_result_if.source          result_out
);
  import wgm_pkg::*;

  localparam int unsigned W      = PATTERN_MAX + 1;
  localparam int unsigned IdxW   = $clog2(W);
  localparam int unsigned LenCap = (PATTERN_MAX < PatternSlots) ? PATTERN_MAX : PatternSlots;

  logic [NumWords-1:0][WordW-1:0] word_q;
  logic [LenW-1:0]                len_q;
  logic [LenW-1:0]                len_eff;

  logic [W-1:0] active_q, active_d;
  logic [W-1:0] star_v, adv_v, set_star, carries, cur;
  logic [W-1:0] sum;
  logic         out_valid_q;
  logic         matched_q;
  logic         out_free;
  logic         end_pop;
  logic         hit;

  always_comb begin
    len_eff = len_q;
    if (len_q > LenW'(LenCap)) begin
      len_eff = LenW'(LenCap);
    end
  end

  for (genvar p = 0; p < W; p++) begin : g_pos
    if (p < PatternSlots) begin : g_slot
      logic [CharW-1:0] pchar;
      logic             in_len;
      assign pchar     = fold_case(word_q[p / 8][(p % 8) * 8 +: 8]);
      assign in_len    = LenW'(p) < len_eff;
      assign star_v[p] = in_len && (pchar == CharStar);
      assign adv_v[p]  = in_len && (pchar != CharStar) &&
                         ((pchar == CharQuery) || (pchar == q_item_i.ch));
    end else begin : g_none
      assign star_v[p] = 1'b0;
      assign adv_v[p]  = 1'b0;
    end
  end

  // Star closure as a carry chain: star positions propagate, set stars generate.
  assign set_star = active_q & star_v;
  assign sum      = set_star + star_v;
  assign carries  = sum ^ set_star ^ star_v;
  assign cur      = active_q | carries;
  assign active_d = (cur & star_v) | ((cur & adv_v) << 1);
  assign hit      = cur[len_eff[IdxW-1:0]];

  assign out_free = !out_valid_q || result_out.ready;
  assign pop_o    = q_valid_i && (!q_item_i.last || out_free);
  assign end_pop  = pop_o && q_item_i.last;

  assign result_out.valid   = out_valid_q;
  assign result_out.matched = matched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      len_q       <= '0;
      active_q    <= W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          REG_WORD_A: word_q[0] <= cfg_i.data;
          REG_WORD_B: word_q[1] <= cfg_i.data;
          REG_WORD_C: word_q[2] <= cfg_i.data;
          REG_WORD_D: word_q[3] <= cfg_i.data;
          REG_LENGTH: len_q     <= cfg_i.data[LenW-1:0];
          default: ;
        endcase
      end
      if (pop_o) begin
        active_q <= q_item_i.last ? W'(1) : active_d;
      end
      if (end_pop) begin
        out_valid_q <= 1'b1;
      end else if (result_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_pop) begin
      matched_q <= hit;
    end
  end

`include "assert_macros.svh"

  `WGM_ASSERT(a_end_restarts, end_pop |=> (active_q == W'(1)) && out_valid_q)
  `WGM_ASSERT(a_no_pop_empty, !q_valid_i |-> !pop_o)

endmodule

`default_nettype wire
